### sv/syslog_stream_deframer_top_defines.svh
// Assertion macros for the syslog stream deframer.
// SDF_ASSERT_IMP checks a same-cycle implication, SDF_ASSERT_NXT a next-cycle one.
`ifndef SYSLOG_STREAM_DEFRAMER_TOP_DEFINES_SVH
`define SYSLOG_STREAM_DEFRAMER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");
`define SDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");
`else
`define SDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### sv/sdf_pkg.sv
`default_nettype none

package sdf_pkg;

  // Fixed field widths
  localparam int unsigned LEN_W   = 34;  // holds a ten-digit decimal prefix
  localparam int unsigned DIGIT_W = 4;   // digit count up to one past ten
  localparam int unsigned CNT_W   = 32;

  // Phase codes
  localparam logic [1:0] PH_PREFIX  = 2'd0;
  localparam logic [1:0] PH_MESSAGE = 2'd1;
  localparam logic [1:0] PH_HALTED  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_NONDIGIT     = 3'd1;
  localparam logic [2:0] ERR_PREFIX_LONG  = 3'd2;
  localparam logic [2:0] ERR_TOO_BIG      = 3'd3;
  localparam logic [2:0] ERR_TRUNC_MSG    = 3'd4;
  localparam logic [2:0] ERR_TRUNC_PREFIX = 3'd5;

  // Register indexes
  localparam logic REG_LEN_FRAMING = 1'b0;
  localparam logic REG_MAX_MSG_LEN = 1'b1;

  localparam logic [31:0] MAX_MSG_LEN_RESET = 32'd65536;

  // Characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             end_of_message;
    logic [CNT_W-1:0] message_number;
    logic [2:0]       error_code;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         phase;
    logic [DIGIT_W-1:0] digit_count;
    logic [LEN_W-1:0]   length_or_remaining;
    logic               cr_pending;
    logic               line_nonempty;
    logic [CNT_W-1:0]   message_count;
  } state_t;

  typedef struct packed {
    logic        len_framing;
    logic [31:0] max_message_length;
  } cfg_t;

endpackage

`default_nettype wire

### sv/sdf_cfg.sv
`default_nettype none

module sdf_cfg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output sdf_pkg::cfg_t     cfg
);

  logic        len_framing_r;
  logic [31:0] max_message_length_r;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_framing_r        <= 1'b0;
      max_message_length_r <= sdf_pkg::MAX_MSG_LEN_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        sdf_pkg::REG_LEN_FRAMING: len_framing_r        <= pwdata[0];
        sdf_pkg::REG_MAX_MSG_LEN: max_message_length_r <= pwdata;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_sel)
      sdf_pkg::REG_LEN_FRAMING: prdata = {31'd0, len_framing_r};
      sdf_pkg::REG_MAX_MSG_LEN: prdata = max_message_length_r;
      default:                  prdata = '0;
    endcase
  end

  assign cfg.len_framing        = len_framing_r;
  assign cfg.max_message_length = max_message_length_r;

endmodule

`default_nettype wire

### sv/sdf_step.sv
`default_nettype none

module sdf_step #(
  parameter int unsigned MAX_PREFIX_DIGITS = 10
) (
  input  wire sdf_pkg::state_t   st,
  input  wire sdf_pkg::in_item_t item,
  input  wire sdf_pkg::cfg_t     cfg,
  output sdf_pkg::state_t        st_nxt,
  output logic                   emit,
  output sdf_pkg::out_item_t     res
);

  localparam logic [sdf_pkg::DIGIT_W-1:0] MAX_DIG = sdf_pkg::DIGIT_W'(MAX_PREFIX_DIGITS);

  logic [7:0]                    b;
  logic                          is_digit;
  logic [sdf_pkg::DIGIT_W-1:0]   dc_inc;
  logic [sdf_pkg::LEN_W-1:0]     len_mac;
  logic [sdf_pkg::LEN_W-1:0]     rem_dec;
  logic [sdf_pkg::CNT_W-1:0]     cnt_inc;
  logic                          halted;

  assign b        = item.data_byte;
  assign is_digit = (b >= sdf_pkg::CH_ZERO) && (b <= sdf_pkg::CH_NINE);
  assign dc_inc   = st.digit_count + 1'b1;
  // x*10 + digit as two shifts and adds
  assign len_mac  = (st.length_or_remaining << 3) + (st.length_or_remaining << 1)
                  + sdf_pkg::LEN_W'(b[3:0]);
  assign rem_dec  = st.length_or_remaining - 1'b1;
  assign cnt_inc  = st.message_count + 1'b1;
  assign halted   = st.phase[1];

  always_comb begin
    st_nxt             = st;
    emit               = 1'b0;
    res                = '0;
    res.message_number = st.message_count;

    if (item.end_of_stream) begin
      // Flush or report truncation, then clear everything
      st_nxt = '0;
      if (!halted) begin
        if (cfg.len_framing) begin
          if (st.phase == sdf_pkg::PH_MESSAGE) begin
            emit           = 1'b1;
            res.error_code = sdf_pkg::ERR_TRUNC_MSG;
          end else if (st.digit_count != '0) begin
            emit           = 1'b1;
            res.error_code = sdf_pkg::ERR_TRUNC_PREFIX;
          end
        end else if (st.line_nonempty) begin
          emit               = 1'b1;
          res.end_of_message = 1'b1;
          res.message_number = cnt_inc;
        end
      end
    end else if (!halted) begin
      if (cfg.len_framing) begin
        if (st.phase == sdf_pkg::PH_MESSAGE) begin
          // Pass a counted byte
          st_nxt.length_or_remaining = rem_dec;
          emit           = 1'b1;
          res.out_byte   = b;
          res.byte_valid = 1'b1;
          if (rem_dec == '0) begin
            st_nxt.phase         = sdf_pkg::PH_PREFIX;
            st_nxt.message_count = cnt_inc;
            res.end_of_message   = 1'b1;
            res.message_number   = cnt_inc;
          end
        end else if (is_digit) begin
          if (dc_inc > MAX_DIG) begin
            st_nxt.phase               = sdf_pkg::PH_HALTED;
            st_nxt.digit_count         = '0;
            st_nxt.length_or_remaining = '0;
            emit                       = 1'b1;
            res.error_code             = sdf_pkg::ERR_PREFIX_LONG;
          end else begin
            st_nxt.digit_count         = dc_inc;
            st_nxt.length_or_remaining = len_mac;
          end
        end else if (b != sdf_pkg::CH_SPACE || st.digit_count == '0) begin
          st_nxt.phase               = sdf_pkg::PH_HALTED;
          st_nxt.digit_count         = '0;
          st_nxt.length_or_remaining = '0;
          emit                       = 1'b1;
          res.error_code             = sdf_pkg::ERR_NONDIGIT;
        end else if (st.length_or_remaining >
                     {2'b00, cfg.max_message_length}) begin
          st_nxt.phase               = sdf_pkg::PH_HALTED;
          st_nxt.digit_count         = '0;
          st_nxt.length_or_remaining = '0;
          emit                       = 1'b1;
          res.error_code             = sdf_pkg::ERR_TOO_BIG;
        end else begin
          // Prefix done; zero length reads the next prefix
          st_nxt.digit_count = '0;
          if (st.length_or_remaining != '0) begin
            st_nxt.phase = sdf_pkg::PH_MESSAGE;
          end
        end
      end else begin
        // Line framing
        st_nxt.cr_pending = 1'b0;
        if (b == sdf_pkg::CH_LF && st.cr_pending) begin
          // LF of a CRLF pair: swallowed
        end else if (b == sdf_pkg::CH_LF || b == sdf_pkg::CH_CR) begin
          st_nxt.cr_pending = (b == sdf_pkg::CH_CR);
          if (st.line_nonempty) begin
            st_nxt.line_nonempty = 1'b0;
            st_nxt.message_count = cnt_inc;
            emit                 = 1'b1;
            res.end_of_message   = 1'b1;
            res.message_number   = cnt_inc;
          end
        end else begin
          st_nxt.line_nonempty = 1'b1;
          emit                 = 1'b1;
          res.out_byte         = b;
          res.byte_valid       = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### sv/syslog_stream_deframer_top.sv
// Syslog stream deframer: takes one stream byte per item and splits the stream into
// messages, by CR/LF/CRLF line ends or by decimal length prefixes (octet counting),
// selected through the configuration port. Each item is handled by combinational
// logic between the framing state registers and one output register, so a new
// item is taken every clock (one item per cycle sustained) as long as the output
// register is empty or being drained in the same cycle; items that produce no
// result never occupy it. Configuration must be written through the APB-style port only
// while the block is idle; the block itself does not enforce this.
`default_nettype none

`include "syslog_stream_deframer_top_defines.svh"

module syslog_stream_deframer_top #(
  parameter int unsigned MAX_PREFIX_DIGITS = 10
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sdf_pkg::in_item_t  in_data,
  // Result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sdf_pkg::out_item_t      out_data,
  // Configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  sdf_pkg::cfg_t      cfg;
  sdf_pkg::state_t    st_r;
  sdf_pkg::state_t    st_nxt;
  sdf_pkg::out_item_t res;
  sdf_pkg::out_item_t out_data_r;
  logic               out_valid_r;
  logic               emit;
  logic               in_acc;

  sdf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sdf_step #(
    .MAX_PREFIX_DIGITS (MAX_PREFIX_DIGITS)
  ) u_step (
    .st     (st_r),
    .item   (in_data),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .emit   (emit),
    .res    (res)
  );

  // Take an item when the output register is free or drains this cycle
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // Framing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `SDF_ASSERT_IMP(a_free_takes, clk, rst_n, !out_valid_r, in_ready)
  `SDF_ASSERT_IMP(a_err_no_byte, clk, rst_n,
                  out_valid_r && out_data_r.error_code != sdf_pkg::ERR_NONE,
                  !out_data_r.byte_valid && !out_data_r.end_of_message)
  `SDF_ASSERT_NXT(a_eos_clears, clk, rst_n, in_acc && in_data.end_of_stream,
                  st_r.phase == sdf_pkg::PH_PREFIX && st_r.message_count == '0)
  `SDF_ASSERT_NXT(a_halt_sticks, clk, rst_n,
                  in_acc && !in_data.end_of_stream && st_r.phase[1],
                  st_r.phase[1] && !(out_valid_r && !$past(out_valid_r && !out_ready)))

endmodule

`default_nettype wire
